// ===== rtl/core/arp_pkg.sv =====
package arp_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W + 1;

  // field widths
  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int ENTRY_W   = IP_W + MAC_W;
  localparam int WAIT_W    = 16;
  localparam int WCNT_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;

  // constants
  localparam logic [IP_W-1:0]   SUBNET_MASK = 32'hffff_ff00;
  localparam logic [MAC_W-1:0]  MAC_BCAST   = 48'hffff_ffff_ffff;
  localparam logic [WCNT_W-1:0] WAIT_MAX    = 17'h1_ffff;
  localparam logic [WAIT_W-1:0] WAIT_RESET  = 16'd100;

  // item modes
  localparam logic [1:0] MODE_RESOLVE = 2'd0;
  localparam logic [1:0] MODE_FRAME   = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  // arp opcodes on the wire
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  // opcodes in results
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_HIT      = 3'd0;
  localparam logic [2:0] KIND_REQUEST  = 3'd1;
  localparam logic [2:0] KIND_REPLY    = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
  localparam logic [2:0] KIND_RESOLVED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIME  = 2'd3;

endpackage

// ===== rtl/core/arp_ram.sv =====
module arp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wen,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/arp_cache_and_responder.sv =====
// flow: a resolve scans the table in S_SCAN and then passes its result through S_EMIT;
//   a resolve on an empty table, or a frame or a tick with a result, goes straight to S_EMIT.
// one request at a time (in_stall is high outside S_IDLE); a resolve scans the table through
//   the single read port of the entry ram, one entry a cycle.
// reset: synchronous, clears the entry count, the pending wait and the handshake state,
//   and loads the register defaults; table contents are not cleared and no sweep runs.
module arp_cache_and_responder (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arp_pkg::CFG_W-1:0]      cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [arp_pkg::IP_W-1:0]       target_ip,
  input  logic [arp_pkg::MAC_W-1:0]      frame_dest_mac,
  input  logic [arp_pkg::MAC_W-1:0]      frame_src_mac,
  input  logic [15:0]                    arp_opcode,
  input  logic [arp_pkg::IP_W-1:0]       arp_sender_ip,
  input  logic [arp_pkg::IP_W-1:0]       arp_target_ip,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_kind,
  output logic [arp_pkg::MAC_W-1:0]      out_mac,
  output logic [arp_pkg::IP_W-1:0]       out_ip,
  output logic [1:0]                     out_opcode
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [arp_pkg::IP_W-1:0]   local_ip;
  logic [arp_pkg::MAC_W-1:0]  local_mac;
  logic [arp_pkg::IP_W-1:0]   gateway_ip;
  logic [arp_pkg::WAIT_W-1:0] wait_time;

  // control state
  logic [arp_pkg::CNT_W-1:0]  entry_count;
  logic                       pending;
  logic [arp_pkg::WCNT_W-1:0] wait_counter;
  logic [arp_pkg::IDX_W-1:0]  idx;

  // working payload
  logic [arp_pkg::IP_W-1:0]   look_ip;
  logic [2:0]                 res_kind;
  logic [arp_pkg::MAC_W-1:0]  res_mac;
  logic [arp_pkg::IP_W-1:0]   res_ip;
  logic [1:0]                 res_opcode;

  // entry ram
  logic                        mem_wen;
  logic [arp_pkg::IDX_W-1:0]   mem_raddr;
  logic [arp_pkg::ENTRY_W-1:0] mem_rdata;
  logic [arp_pkg::IP_W-1:0]    rd_ip;
  logic [arp_pkg::MAC_W-1:0]   rd_mac;

  // decode of the incoming request
  logic                       accept;
  logic [arp_pkg::IP_W-1:0]   resolve_ip;
  logic                       to_local_mac;
  logic                       is_reply;
  logic                       table_full;
  logic                       is_request_for_us;
  logic [arp_pkg::WCNT_W-1:0] wait_inc;
  logic                       timed_out;
  logic                       scan_hit;
  logic                       scan_last;
  logic                       out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // off-subnet targets go to the gateway
  assign resolve_ip = ((target_ip & arp_pkg::SUBNET_MASK) != (local_ip & arp_pkg::SUBNET_MASK))
                    ? gateway_ip : target_ip;

  assign to_local_mac      = (frame_dest_mac == local_mac);
  assign is_reply          = (arp_opcode == arp_pkg::ARP_OP_REPLY);
  assign table_full        = (entry_count >= arp_pkg::CNT_W'(arp_pkg::TABLE_DEPTH));
  assign is_request_for_us = (frame_dest_mac == arp_pkg::MAC_BCAST)
                          && (arp_opcode == arp_pkg::ARP_OP_REQUEST)
                          && (arp_target_ip == local_ip);

  // saturating tick count
  assign wait_inc  = (wait_counter == arp_pkg::WAIT_MAX) ? wait_counter
                   : wait_counter + arp_pkg::WCNT_W'(1);
  assign timed_out = (wait_inc > {1'b0, wait_time});

  // append on a reply to us with room in the table
  assign mem_wen = accept && (mode == arp_pkg::MODE_FRAME) && to_local_mac && is_reply
                && !table_full;

  // scan reads entry 0 first, then walks one entry per cycle
  assign mem_raddr = (state == S_IDLE) ? '0 : idx + arp_pkg::IDX_W'(1);
  assign rd_ip     = mem_rdata[arp_pkg::IP_W-1:0];
  assign rd_mac    = mem_rdata[arp_pkg::ENTRY_W-1:arp_pkg::IP_W];
  assign scan_hit  = (rd_ip == look_ip);
  assign scan_last = (({1'b0, idx} + arp_pkg::CNT_W'(1)) == entry_count);

  // result moves to the output register when it is free or being taken
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  arp_ram #(
    .WIDTH (arp_pkg::ENTRY_W),
    .DEPTH (arp_pkg::TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (entry_count[arp_pkg::IDX_W-1:0]),
    .wdata ({frame_src_mac, arp_sender_ip}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip   <= '0;
      local_mac  <= '0;
      gateway_ip <= '0;
      wait_time  <= arp_pkg::WAIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        arp_pkg::CFG_LOCAL_IP:   local_ip   <= cfg_data[arp_pkg::IP_W-1:0];
        arp_pkg::CFG_LOCAL_MAC:  local_mac  <= cfg_data[arp_pkg::MAC_W-1:0];
        arp_pkg::CFG_GATEWAY_IP: gateway_ip <= cfg_data[arp_pkg::IP_W-1:0];
        arp_pkg::CFG_WAIT_TIME:  wait_time  <= cfg_data[arp_pkg::WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // request sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      pending      <= 1'b0;
      wait_counter <= '0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      // taken result empties the output register unless a new one lands
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              arp_pkg::MODE_RESOLVE: begin
                look_ip <= resolve_ip;
                idx     <= '0;
                if (entry_count == '0) begin
                  // empty table: straight to a broadcast request
                  pending      <= 1'b1;
                  wait_counter <= '0;
                  res_kind     <= arp_pkg::KIND_REQUEST;
                  res_mac      <= arp_pkg::MAC_BCAST;
                  res_ip       <= resolve_ip;
                  res_opcode   <= arp_pkg::OP_REQUEST;
                  state        <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              arp_pkg::MODE_FRAME: begin
                if (to_local_mac) begin
                  if (is_reply && !table_full) begin
                    entry_count <= entry_count + arp_pkg::CNT_W'(1);
                    if (pending) begin
                      pending    <= 1'b0;
                      res_kind   <= arp_pkg::KIND_RESOLVED;
                      res_mac    <= frame_src_mac;
                      res_ip     <= arp_sender_ip;
                      res_opcode <= arp_pkg::OP_NONE;
                      state      <= S_EMIT;
                    end
                  end
                end else if (is_request_for_us) begin
                  res_kind   <= arp_pkg::KIND_REPLY;
                  res_mac    <= frame_src_mac;
                  res_ip     <= arp_sender_ip;
                  res_opcode <= arp_pkg::OP_REPLY;
                  state      <= S_EMIT;
                end
              end
              arp_pkg::MODE_TICK: begin
                if (pending) begin
                  wait_counter <= wait_inc;
                  if (timed_out) begin
                    pending    <= 1'b0;
                    res_kind   <= arp_pkg::KIND_TIMEOUT;
                    res_mac    <= arp_pkg::MAC_BCAST;
                    res_ip     <= '0;
                    res_opcode <= arp_pkg::OP_NONE;
                    state      <= S_EMIT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // entry idx is on the ram output this cycle
          if (scan_hit) begin
            res_kind   <= arp_pkg::KIND_HIT;
            res_mac    <= rd_mac;
            res_ip     <= look_ip;
            res_opcode <= arp_pkg::OP_NONE;
            state      <= S_EMIT;
          end else if (scan_last) begin
            pending      <= 1'b1;
            wait_counter <= '0;
            res_kind     <= arp_pkg::KIND_REQUEST;
            res_mac      <= arp_pkg::MAC_BCAST;
            res_ip       <= look_ip;
            res_opcode   <= arp_pkg::OP_REQUEST;
            state        <= S_EMIT;
          end else begin
            idx <= idx + arp_pkg::IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid  <= 1'b1;
            out_kind   <= res_kind;
            out_mac    <= res_mac;
            out_ip     <= res_ip;
            out_opcode <= res_opcode;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= arp_pkg::CNT_W'(arp_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // scan only visits stored entries
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, idx} < entry_count))
    else $error("scan index past entry count");

  // appends happen only between requests and with room left
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_wen |-> ((state == S_IDLE) && (entry_count < arp_pkg::CNT_W'(arp_pkg::TABLE_DEPTH))))
    else $error("table write outside idle or into full table");

  // a broadcast request always leaves a wait pending
  a_request_pending: assert property (@(posedge clk) disable iff (rst)
    (out_load && (res_kind == arp_pkg::KIND_REQUEST)) |-> pending)
    else $error("request sent without pending wait");

  // a loaded result is presented next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ===== tb/sv/arp_check_pkg.sv =====
package arp_check_pkg;
  import arp_pkg::*;

  // one request as driven on the request channel
  typedef struct {
    bit [1:0]       mode;
    bit [IP_W-1:0]  target_ip;
    bit [MAC_W-1:0] dst_mac;
    bit [MAC_W-1:0] src_mac;
    bit [15:0]      opcode;
    bit [IP_W-1:0]  sender_ip;
    bit [IP_W-1:0]  arp_tip;
  } arp_req_t;

  // one result as seen on the result channel
  typedef struct {
    logic [2:0]       kind;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic [1:0]       opcode;
  } arp_res_t;

  // mirror of the cache and responder, plus the results it owes
  class arp_cache_tracker;
    bit [IP_W-1:0]   local_ip;
    bit [MAC_W-1:0]  local_mac;
    bit [IP_W-1:0]   gateway_ip;
    bit [WAIT_W-1:0] wait_time;

    bit [IP_W-1:0]   tbl_ip[TABLE_DEPTH];
    bit [MAC_W-1:0]  tbl_mac[TABLE_DEPTH];
    int unsigned     tbl_count;
    bit              pending;
    bit [WCNT_W-1:0] ticks_waited;

    arp_res_t        awaited_results[$];
    int unsigned     failures;
    int unsigned     checked;
    int unsigned     kind_seen[5];

    function new();
      wait_time = WAIT_RESET;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
      case (idx)
        CFG_LOCAL_IP:   local_ip   = data[IP_W-1:0];
        CFG_LOCAL_MAC:  local_mac  = data[MAC_W-1:0];
        CFG_GATEWAY_IP: gateway_ip = data[IP_W-1:0];
        CFG_WAIT_TIME:  wait_time  = data[WAIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void owe(bit [2:0] kind, bit [MAC_W-1:0] mac, bit [IP_W-1:0] ip, bit [1:0] op);
      arp_res_t r;
      r.kind   = kind;
      r.mac    = mac;
      r.ip     = ip;
      r.opcode = op;
      awaited_results.push_back(r);
    endfunction

    function void note_request(arp_req_t r);
      bit [IP_W-1:0] addr;
      bit            found;
      case (r.mode)
        MODE_RESOLVE: begin
          // off-subnet targets go through the gateway
          addr = r.target_ip;
          if ((addr & SUBNET_MASK) != (local_ip & SUBNET_MASK)) addr = gateway_ip;
          found = 1'b0;
          for (int i = 0; i < tbl_count; i++) begin
            if (!found && tbl_ip[i] == addr) begin
              found = 1'b1;
              owe(KIND_HIT, tbl_mac[i], addr, OP_NONE);
            end
          end
          if (!found) begin
            pending      = 1'b1;
            ticks_waited = '0;
            owe(KIND_REQUEST, MAC_BCAST, addr, OP_REQUEST);
          end
        end
        MODE_FRAME: begin
          // local mac match is tested before broadcast
          if (r.dst_mac == local_mac) begin
            if (r.opcode == ARP_OP_REPLY && tbl_count < TABLE_DEPTH) begin
              tbl_ip[tbl_count]  = r.sender_ip;
              tbl_mac[tbl_count] = r.src_mac;
              tbl_count++;
              if (pending) begin
                pending = 1'b0;
                owe(KIND_RESOLVED, r.src_mac, r.sender_ip, OP_NONE);
              end
            end
          end else if (r.dst_mac == MAC_BCAST && r.opcode == ARP_OP_REQUEST &&
                       r.arp_tip == local_ip) begin
            owe(KIND_REPLY, r.src_mac, r.sender_ip, OP_REPLY);
          end
        end
        MODE_TICK: begin
          if (pending) begin
            if (ticks_waited != WAIT_MAX) ticks_waited++;
            if (ticks_waited > {1'b0, wait_time}) begin
              pending = 1'b0;
              owe(KIND_TIMEOUT, MAC_BCAST, '0, OP_NONE);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(arp_res_t got);
      arp_res_t want;
      if (awaited_results.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d mac %h ip %h opcode %0d",
                       got.kind, got.mac, got.ip, got.opcode));
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (want.kind <= KIND_RESOLVED) kind_seen[want.kind]++;
      if (got.kind !== want.kind || got.mac !== want.mac || got.ip !== want.ip ||
          got.opcode !== want.opcode)
        flag($sformatf({"mismatch on result %0d (expected/actual): kind %0d/%0d ",
                        "mac %h/%h ip %h/%h opcode %0d/%0d"},
                       checked, want.kind, got.kind, want.mac, got.mac, want.ip, got.ip,
                       want.opcode, got.opcode));
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    function void close_out();
      if (awaited_results.size() != 0)
        flag($sformatf("%0d results never arrived", awaited_results.size()));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arp_pkg::*;
  import arp_check_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           mode = '0;
  logic [IP_W-1:0]      target_ip = '0;
  logic [MAC_W-1:0]     frame_dest_mac = '0;
  logic [MAC_W-1:0]     frame_src_mac = '0;
  logic [15:0]          arp_opcode = '0;
  logic [IP_W-1:0]      arp_sender_ip = '0;
  logic [IP_W-1:0]      arp_target_ip = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_kind;
  logic [MAC_W-1:0]     out_mac;
  logic [IP_W-1:0]      out_ip;
  logic [1:0]           out_opcode;

  arp_cache_tracker cache;
  bit               quiet;
  int unsigned      cycles;
  int unsigned      sent;

  always #6 clk = ~clk;

  arp_cache_and_responder dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .target_ip(target_ip),
    .frame_dest_mac(frame_dest_mac), .frame_src_mac(frame_src_mac),
    .arp_opcode(arp_opcode), .arp_sender_ip(arp_sender_ip), .arp_target_ip(arp_target_ip),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind), .out_mac(out_mac),
    .out_ip(out_ip), .out_opcode(out_opcode)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    arp_res_t seen;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      seen.kind   = out_kind;
      seen.mac    = out_mac;
      seen.ip     = out_ip;
      seen.opcode = out_opcode;
      cache.check_result(seen);
    end
  end

  function automatic int unsigned idle_draw();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic bit [MAC_W-1:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  // receiver stalls a random number of cycles before each result
  initial begin : result_sink
    int unsigned k;
    forever begin
      k = idle_draw();
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
    end
  end

  // drive one request and wait until it is taken
  task automatic send_request(input arp_req_t r);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode           <= r.mode;
    target_ip      <= r.target_ip;
    frame_dest_mac <= r.dst_mac;
    frame_src_mac  <= r.src_mac;
    arp_opcode     <= r.opcode;
    arp_sender_ip  <= r.sender_ip;
    arp_target_ip  <= r.arp_tip;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    cache.note_request(r);
    sent++;
  endtask

  // drop valid, let every owed result come out, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (cache.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back
  task automatic configure(input bit [IP_W-1:0] ip, input bit [MAC_W-1:0] mac,
                           input bit [IP_W-1:0] gw, input bit [WAIT_W-1:0] wt);
    bit [CFG_W-1:0] vals[4];
    vals[CFG_LOCAL_IP]   = CFG_W'(ip);
    vals[CFG_LOCAL_MAC]  = CFG_W'(mac);
    vals[CFG_GATEWAY_IP] = CFG_W'(gw);
    vals[CFG_WAIT_TIME]  = CFG_W'(wt);
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      cache.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic arp_req_t resolve(bit [IP_W-1:0] ip);
    arp_req_t r;
    r = '{default: '0};
    r.mode      = MODE_RESOLVE;
    r.target_ip = ip;
    return r;
  endfunction

  function automatic arp_req_t tick();
    arp_req_t r;
    r = '{default: '0};
    r.mode = MODE_TICK;
    return r;
  endfunction

  function automatic arp_req_t frame(bit [MAC_W-1:0] dst, bit [MAC_W-1:0] src, bit [15:0] op,
                                     bit [IP_W-1:0] sip, bit [IP_W-1:0] tip);
    arp_req_t r;
    r.mode      = MODE_FRAME;
    r.target_ip = $urandom;
    r.dst_mac   = dst;
    r.src_mac   = src;
    r.opcode    = op;
    r.sender_ip = sip;
    r.arp_tip   = tip;
    return r;
  endfunction

  // mostly hosts on the local subnet so lookups hit, some via the gateway
  function automatic bit [IP_W-1:0] host_addr();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return cache.gateway_ip;
      default: return {cache.local_ip[31:8], 8'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic arp_req_t random_request();
    arp_req_t    r;
    int unsigned pick;
    bit [15:0]   odd_ops[5];
    odd_ops = '{16'h0000, ARP_OP_REQUEST, ARP_OP_REPLY, 16'h0003, 16'hffff};
    r.mode      = 2'($urandom_range(0, 3));
    r.target_ip = $urandom;
    r.dst_mac   = rand_mac();
    r.src_mac   = rand_mac();
    r.opcode    = 16'($urandom);
    r.sender_ip = $urandom;
    r.arp_tip   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r = resolve(host_addr());
    end else if (pick < 62) begin
      r = tick();
    end else if (pick < 64) begin
      // reply to us: fills the table and finishes a waiting resolve
      r = frame(cache.local_mac, rand_mac(), ARP_OP_REPLY, host_addr(), $urandom);
    end else if (pick < 74) begin
      r = frame(MAC_BCAST, rand_mac(), ARP_OP_REQUEST, $urandom,
                ($urandom_range(0, 3) != 0) ? cache.local_ip : host_addr());
    end else if (pick < 84) begin
      // near misses on destination and opcode
      r = frame(($urandom_range(0, 1) != 0) ? cache.local_mac : MAC_BCAST, rand_mac(),
                odd_ops[$urandom_range(0, 4)], host_addr(),
                ($urandom_range(0, 1) != 0) ? cache.local_ip : $urandom);
    end
    return r;
  endfunction

  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      send_request(random_request());
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    bit [MAC_W-1:0] our_mac;
    cache   = new();
    our_mac = 48'h02aa_bb00_0001;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset
    send_request(tick());
    send_request('{2'd3, '1, '1, '1, '1, '1, '1});
    send_request(resolve(32'h0000_00ff));
    send_request(frame('0, MAC_BCAST, ARP_OP_REPLY, 32'h0000_00ff, '0));
    settle();

    configure(32'hc0a8_0a05, our_mac, 32'hc0a8_0a01, 16'd0);
    // gateway substitution, restart of a wait, zero wait timeout
    send_request(resolve(32'hffff_ffff));
    send_request(resolve(32'hc0a8_0a07));
    send_request(tick());
    send_request(tick());
    // reply finishes a resolve, a second entry with the same address loses
    send_request(resolve(32'hc0a8_0a07));
    send_request(frame(our_mac, 48'h0000_1111_2222, ARP_OP_REPLY, 32'hc0a8_0a07, '0));
    send_request(frame(our_mac, 48'h0000_3333_4444, ARP_OP_REPLY, 32'hc0a8_0a07, '0));
    send_request(resolve(32'hc0a8_0a07));
    // hit while waiting leaves the wait alone
    send_request(resolve(32'h0000_0000));
    send_request(resolve(32'hc0a8_0a07));
    // answered request and frames that are ignored
    send_request(frame(MAC_BCAST, 48'h0a0b_0c0d_0e0f, ARP_OP_REQUEST, 32'h0a0b_0c0d,
                       32'hc0a8_0a05));
    send_request(frame(MAC_BCAST, rand_mac(), ARP_OP_REQUEST, $urandom, 32'hc0a8_0a06));
    send_request(frame(MAC_BCAST, rand_mac(), 16'hffff, $urandom, 32'hc0a8_0a05));
    send_request(frame(48'h0000_0000_0001, rand_mac(), ARP_OP_REPLY, $urandom, '0));
    send_request(frame(our_mac, rand_mac(), 16'h0000, $urandom, '0));
    send_request(tick());
    settle();

    // all-ones local mac: broadcast frames take the append path, never the reply path
    configure(32'hc0a8_0a05, MAC_BCAST, 32'hc0a8_0a01, 16'd3);
    send_request(frame(MAC_BCAST, rand_mac(), ARP_OP_REQUEST, $urandom, 32'hc0a8_0a05));
    send_request(resolve(32'hc0a8_0a33));
    send_request(frame(MAC_BCAST, 48'h5555_aaaa_5555, ARP_OP_REPLY, 32'hc0a8_0a33, '0));
    send_request(resolve(32'hc0a8_0a33));
    run_random(150);
    settle();

    configure('0, '0, 32'hffff_ffff, 16'hffff);
    run_random(150);
    settle();

    configure(32'hffff_ffff, rand_mac(), '0, 16'd12);
    run_random(150);
    settle();

    configure(32'hc0a8_0a05, our_mac, 32'hc0a8_0a01, WAIT_RESET);
    run_random(150);
    settle();

    configure(32'h0a00_0164, rand_mac(), 32'h0a00_0001, 16'd1);
    run_random(270);
    settle();

    cache.close_out();
    $display("%0d requests taken, %0d results checked: %0d hits, %0d arp requests, %0d replies",
             sent, cache.checked, cache.kind_seen[KIND_HIT], cache.kind_seen[KIND_REQUEST],
             cache.kind_seen[KIND_REPLY]);
    $display("%0d timeouts, %0d resolved by reply, table ended with %0d of %0d entries",
             cache.kind_seen[KIND_TIMEOUT], cache.kind_seen[KIND_RESOLVED], cache.tbl_count,
             TABLE_DEPTH);
    if (cache.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", cache.failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== arp_cache_and_responder.f =====
rtl/core/arp_pkg.sv
rtl/core/arp_ram.sv
rtl/core/arp_cache_and_responder.sv
tb/sv/arp_check_pkg.sv
tb/sv/tb.sv
